FILE: src/hsv2rgb_pkg.sv
// Shared constants and types for the HSV to RGB converter.
package hsv2rgb_pkg;

    localparam int unsigned HUE_W      = 13;
    localparam int unsigned CHAN_W     = 9;
    localparam int unsigned FRAC_W     = 8;
    localparam int unsigned REM_W      = 10;
    localparam int unsigned PROD_W     = 17;

    localparam logic [HUE_W-1:0]  HUE_FULL_TURN = 13'd5760;
    localparam logic [HUE_W-1:0]  HUE_SECTOR    = 13'd960;
    localparam logic [CHAN_W-1:0] ONE_Q8        = 9'd256;
    localparam logic [PROD_W-1:0] ONE_Q16       = 17'h10000;

    // floor(x / 15) == (x * FRAC_RECIP) >> 16 for x below 3840
    localparam logic [12:0]       FRAC_RECIP    = 13'd4370;

    typedef enum logic [2:0] {
        SEC_RED_YEL  = 3'd0,
        SEC_YEL_GRN  = 3'd1,
        SEC_GRN_CYN  = 3'd2,
        SEC_CYN_BLU  = 3'd3,
        SEC_BLU_MAG  = 3'd4,
        SEC_MAG_RED  = 3'd5
    } t_sector;

endpackage

FILE: src/hsv2rgb_if.sv
// Valid/ready channel interfaces for HSV items in and RGB items out.
interface hsv2rgb_in_if;
    logic                               valid;
    logic                               ready;
    logic [hsv2rgb_pkg::HUE_W-1:0]      hue;
    logic                               hue_undefined;
    logic [hsv2rgb_pkg::CHAN_W-1:0]     saturation;
    logic [hsv2rgb_pkg::CHAN_W-1:0]     brightness;

    modport source (output valid, hue, hue_undefined, saturation, brightness, input ready);
    modport sink   (input valid, hue, hue_undefined, saturation, brightness, output ready);
endinterface

interface hsv2rgb_out_if;
    logic                               valid;
    logic                               ready;
    logic [hsv2rgb_pkg::CHAN_W-1:0]     red;
    logic [hsv2rgb_pkg::CHAN_W-1:0]     green;
    logic [hsv2rgb_pkg::CHAN_W-1:0]     blue;
    logic                               bad_input;

    modport source (output valid, red, green, blue, bad_input, input ready);
    modport sink   (input valid, red, green, blue, bad_input, output ready);
endinterface

FILE: src/hsv_to_rgb_converter.sv
// HSV to RGB converter: four-stage pipeline, one item per clock unless stalled.
//
// Channels: i_hsv takes hue (1/16 degree), hue_undefined, saturation and
// brightness (Q1.8); o_rgb returns red, green, blue (Q1.8) and bad_input.
// An item moves on each rising edge where valid and ready are both high.
// Throughput: one item per cycle unless stalled, set by the four register
// stages (sector split, fraction and v(1-s), the two s*f products, the two
// v products with channel selection into the output register).
// Path: an accepted item passes the stage registers r1, r2 and r3 into the
// output register r4, which drives o_rgb and holds while the output is stalled.
// Reset: i_rst_n low at a clock edge clears all stage valid bits; items in
// flight are dropped.
// Stall: while o_rgb.ready is low and a result is waiting, the whole
// pipeline holds, bubbles included, and i_hsv.ready is low; an item is
// taken whenever the output register is empty or being drained.
module hsv_to_rgb_converter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    hsv2rgb_in_if.sink          i_hsv,
    hsv2rgb_out_if.source       o_rgb
);
    import hsv2rgb_pkg::*;

    logic                   w_adv;
    logic [CHAN_W-1:0]      w_s;
    logic [CHAN_W-1:0]      w_v;
    logic [HUE_W-1:0]       w_hue;
    t_sector                w_sec;
    logic [HUE_W-1:0]       w_base;
    logic [HUE_W-1:0]       w_rem;
    logic [24:0]            w_fprod;
    logic [17:0]            w_mprod;
    logic [FRAC_W:0]        w_f_inv;
    logic [PROD_W-1:0]      w_sf;
    logic [PROD_W-1:0]      w_sfi;
    logic [25:0]            w_nprod;
    logic [25:0]            w_kprod;
    logic [CHAN_W-1:0]      w_n;
    logic [CHAN_W-1:0]      w_k;
    logic [CHAN_W-1:0]      n_red;
    logic [CHAN_W-1:0]      n_green;
    logic [CHAN_W-1:0]      n_blue;

    logic                   r1_valid, r2_valid, r3_valid, r4_valid;
    t_sector                r1_sec, r2_sec, r3_sec;
    logic [REM_W-1:0]       r1_rem;
    logic [CHAN_W-1:0]      r1_s, r2_s;
    logic [CHAN_W-1:0]      r1_v, r2_v, r3_v;
    logic                   r1_szero, r2_szero, r3_szero;
    logic                   r1_undef, r2_undef, r3_undef;
    logic [FRAC_W-1:0]      r2_f;
    logic [CHAN_W-1:0]      r2_m, r3_m;
    logic [PROD_W-1:0]      r3_tn, r3_tk;
    logic [CHAN_W-1:0]      r4_red, r4_green, r4_blue;
    logic                   r4_bad;

    assign w_adv       = !r4_valid || o_rgb.ready;
    assign i_hsv.ready = w_adv;

    // stage 1: clamp, zero an undefined or out-of-range hue, split into sector and remainder
    always_comb begin
        w_s   = (i_hsv.saturation > ONE_Q8) ? ONE_Q8 : i_hsv.saturation;
        w_v   = (i_hsv.brightness > ONE_Q8) ? ONE_Q8 : i_hsv.brightness;
        w_hue = (i_hsv.hue_undefined || i_hsv.hue >= HUE_FULL_TURN) ? '0 : i_hsv.hue;
        if (w_hue >= HUE_SECTOR * 5) begin
            w_sec = SEC_MAG_RED;
        end else if (w_hue >= HUE_SECTOR * 4) begin
            w_sec = SEC_BLU_MAG;
        end else if (w_hue >= HUE_SECTOR * 3) begin
            w_sec = SEC_CYN_BLU;
        end else if (w_hue >= HUE_SECTOR * 2) begin
            w_sec = SEC_GRN_CYN;
        end else if (w_hue >= HUE_SECTOR) begin
            w_sec = SEC_YEL_GRN;
        end else begin
            w_sec = SEC_RED_YEL;
        end
        case (w_sec)
            SEC_RED_YEL: w_base = '0;
            SEC_YEL_GRN: w_base = HUE_SECTOR;
            SEC_GRN_CYN: w_base = HUE_W'(HUE_SECTOR * 2);
            SEC_CYN_BLU: w_base = HUE_W'(HUE_SECTOR * 3);
            SEC_BLU_MAG: w_base = HUE_W'(HUE_SECTOR * 4);
            SEC_MAG_RED: w_base = HUE_W'(HUE_SECTOR * 5);
            default:     w_base = '0;
        endcase
        w_rem = w_hue - w_base;
    end

    // stage 2: fraction = rem * 4 / 15, and m = v(1-s)
    assign w_fprod = {13'd0, r1_rem, 2'b00} * {12'd0, FRAC_RECIP};
    assign w_mprod = {9'd0, r1_v} * {9'd0, (ONE_Q8 - r1_s)};

    // stage 3: s*f and s*(1-f) subtracted from one
    assign w_f_inv = ONE_Q8 - {1'b0, r2_f};
    assign w_sf    = {8'd0, r2_s} * {9'd0, r2_f};
    assign w_sfi   = {8'd0, r2_s} * {8'd0, w_f_inv};

    // stage 4: v products and channel selection
    assign w_nprod = {17'd0, r3_v} * {9'd0, r3_tn};
    assign w_kprod = {17'd0, r3_v} * {9'd0, r3_tk};
    assign w_n     = w_nprod[24:16];
    assign w_k     = w_kprod[24:16];

    always_comb begin
        case (r3_sec)
            SEC_RED_YEL: begin n_red = r3_v; n_green = w_k;  n_blue = r3_m; end
            SEC_YEL_GRN: begin n_red = w_n;  n_green = r3_v; n_blue = r3_m; end
            SEC_GRN_CYN: begin n_red = r3_m; n_green = r3_v; n_blue = w_k;  end
            SEC_CYN_BLU: begin n_red = r3_m; n_green = w_n;  n_blue = r3_v; end
            SEC_BLU_MAG: begin n_red = w_k;  n_green = r3_m; n_blue = r3_v; end
            default:     begin n_red = r3_v; n_green = r3_m; n_blue = w_n;  end
        endcase
        if (r3_szero) begin
            n_red   = r3_undef ? r3_v : '0;
            n_green = r3_undef ? r3_v : '0;
            n_blue  = r3_undef ? r3_v : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (w_adv) begin
            r1_valid <= i_hsv.valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_sec   <= w_sec;
            r1_rem   <= w_rem[REM_W-1:0];
            r1_s     <= w_s;
            r1_v     <= w_v;
            r1_szero <= (w_s == '0);
            r1_undef <= i_hsv.hue_undefined;

            r2_sec   <= r1_sec;
            r2_s     <= r1_s;
            r2_v     <= r1_v;
            r2_szero <= r1_szero;
            r2_undef <= r1_undef;
            r2_f     <= w_fprod[23:16];
            r2_m     <= w_mprod[16:8];

            r3_sec   <= r2_sec;
            r3_v     <= r2_v;
            r3_szero <= r2_szero;
            r3_undef <= r2_undef;
            r3_m     <= r2_m;
            r3_tn    <= ONE_Q16 - w_sf;
            r3_tk    <= ONE_Q16 - w_sfi;

            r4_red   <= n_red;
            r4_green <= n_green;
            r4_blue  <= n_blue;
            r4_bad   <= r3_szero && !r3_undef;
        end
    end

    assign o_rgb.valid     = r4_valid;
    assign o_rgb.red       = r4_red;
    assign o_rgb.green     = r4_green;
    assign o_rgb.blue      = r4_blue;
    assign o_rgb.bad_input = r4_bad;

endmodule
